FILE: sv/fir_q8_pkg.sv
`timescale 1ns / 1ps

package fir_q8_pkg;

  localparam int SampleW     = 21;
  localparam int FiltW       = 23;
  localparam int CoefW       = 8;
  localparam int TableDepth  = 24;
  localparam int TapsDef     = 24;
  localparam int FracBitsDef = 8;

  // Q8 coefficients, index 0 applies to the newest sample
  localparam logic signed [CoefW-1:0] CoefTable [TableDepth] = '{
    8'sd1,   8'sd1,   8'sd0,   -8'sd1,  8'sd0,   8'sd0,   -8'sd2,  8'sd1,
    8'sd1,   -8'sd3,  8'sd0,   8'sd2,   -8'sd4,  8'sd0,   8'sd5,   -8'sd5,
    -8'sd2,  8'sd10,  -8'sd6,  -8'sd8,  8'sd19,  -8'sd7,  -8'sd30, 8'sd73
  };

  // taps past the end of the table carry a zero coefficient
  function automatic logic signed [CoefW-1:0] coef(input int k);
    logic signed [CoefW-1:0] c;
    c = '0;
    if (k >= 0 && k < TableDepth) begin
      c = CoefTable[k[4:0]];
    end
    return c;
  endfunction

endpackage

FILE: sv/fir_q8_datapath.sv
`timescale 1ns / 1ps

module fir_q8_datapath #(
  parameter int TAPS      = fir_q8_pkg::TapsDef,
  parameter int FRAC_BITS = fir_q8_pkg::FracBitsDef
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     shift_i,
  input  logic signed [fir_q8_pkg::SampleW-1:0]    sample_i,
  output logic signed [fir_q8_pkg::FiltW-1:0]      filtered_o
);

  localparam int ProdW = fir_q8_pkg::SampleW + fir_q8_pkg::CoefW;
  localparam int AccW  = ProdW + $clog2(TAPS) + 1;
  localparam logic signed [ProdW-1:0] Bias   = ProdW'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [AccW-1:0]  OutMax = AccW'((64'sd1 <<< (fir_q8_pkg::FiltW - 1)) - 64'sd1);
  localparam logic signed [AccW-1:0]  OutMin = -AccW'(64'sd1 <<< (fir_q8_pkg::FiltW - 1));

  logic signed [fir_q8_pkg::SampleW-1:0] line_q [TAPS];
  logic signed [fir_q8_pkg::SampleW-1:0] line_d [TAPS];
  logic signed [ProdW-1:0]               prod   [TAPS];
  logic signed [ProdW-1:0]               trunc  [TAPS];
  logic signed [AccW-1:0]                acc;

  // line contents once the new word has been shifted in
  always_comb begin
    line_d[0] = sample_i;
    for (int k = 1; k < TAPS; k++) begin
      line_d[k] = line_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        line_q[k] <= '0;
      end
    end else if (shift_i) begin
      for (int k = 0; k < TAPS; k++) begin
        line_q[k] <= line_d[k];
      end
    end
  end

  // constant-coefficient products, each scaled down rounding toward zero
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      prod[k]  = ProdW'(line_d[k]) * ProdW'(fir_q8_pkg::coef(k));
      trunc[k] = (prod[k] + (prod[k][ProdW-1] ? Bias : ProdW'(0))) >>> FRAC_BITS;
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + AccW'(trunc[k]);
    end
  end

  always_comb begin
    if (acc > OutMax) begin
      filtered_o = OutMax[fir_q8_pkg::FiltW-1:0];
    end else if (acc < OutMin) begin
      filtered_o = OutMin[fir_q8_pkg::FiltW-1:0];
    end else begin
      filtered_o = acc[fir_q8_pkg::FiltW-1:0];
    end
  end

endmodule

FILE: sv/fir_filter_q8.sv
`timescale 1ns / 1ps

// FIR filter with a fixed built-in set of Q8 coefficients. Each
// accepted word is shifted into the delay line and the filtered word, the
// saturated sum of all TAPS products (each scaled down by 2^FRAC_BITS toward
// zero), appears on the output in the next cycle. One word is taken
// every cycle while the output keeps being read: the products and adder
// tree sit in a single combinational pass in front of the output register,
// and a new word is accepted whenever that register is empty or being
// read in the same cycle. The delay line resets to zero.
module fir_filter_q8 #(
  parameter int TAPS      = fir_q8_pkg::TapsDef,
  parameter int FRAC_BITS = fir_q8_pkg::FracBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [fir_q8_pkg::SampleW-1:0] sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [fir_q8_pkg::FiltW-1:0]   filtered_o
);

  logic                                 accept;
  logic                                 out_valid_q, out_valid_d;
  logic signed [fir_q8_pkg::FiltW-1:0]  filtered_q;
  logic signed [fir_q8_pkg::FiltW-1:0]  filtered_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  fir_q8_datapath #(
    .TAPS      (TAPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (accept),
    .sample_i   (sample_i),
    .filtered_o (filtered_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      filtered_q <= filtered_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted sample produced no output word");

  a_word_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("output word appeared without an accepted sample");

  a_drain_only_when_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i) && !$past(in_valid_i))
    else $error("output word dropped without being read");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int SampleW     = fir_q8_pkg::SampleW;
  localparam int FiltW       = fir_q8_pkg::FiltW;
  localparam int TapsDef     = fir_q8_pkg::TapsDef;
  localparam int TableDepth  = fir_q8_pkg::TableDepth;
  localparam int FracBitsDef = fir_q8_pkg::FracBitsDef;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [FiltW-1:0]   filtered_o;

  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam longint FiltMax = (longint'(1) <<< (FiltW-1)) - 1;
  localparam longint FiltMin = -(longint'(1) <<< (FiltW-1));

  // model of the delay line and the words still owed by the block
  logic signed [SampleW-1:0] history [TapsDef] = '{default: '0};
  logic signed [FiltW-1:0]   filtered_q [$];

  int unsigned errors    = 0;
  bit          src_gaps  = 1'b0;
  bit          sink_gaps = 1'b0;
  int unsigned hold_reqs = 0;

  fir_filter_q8 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filtered_o  (filtered_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("tb failed");
    $finish;
  end

  // shift one sample in and form the saturated sum of truncated products
  function automatic logic signed [FiltW-1:0] filter_sample(
    input logic signed [SampleW-1:0] s
  );
    longint acc;
    longint prod;
    longint c;
    for (int k = TapsDef - 1; k > 0; k--) begin
      history[k] = history[k-1];
    end
    history[0] = s;
    acc = 0;
    for (int k = 0; k < TapsDef; k++) begin
      c = (k < TableDepth) ? longint'(fir_q8_pkg::CoefTable[k]) : 0;
      prod = longint'(history[k]) * c;
      // signed division truncates toward zero, as the hardware must
      acc += prod / (longint'(1) <<< FracBitsDef);
    end
    if (acc > FiltMax) acc = FiltMax;
    if (acc < FiltMin) acc = FiltMin;
    return FiltW'(acc);
  endfunction

  // handshakes are judged at the falling edge, where everything is settled
  always @(negedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      filtered_q.push_back(filter_sample(sample_i));
    end
  end

  always @(negedge clk_i) begin : check_out
    logic signed [FiltW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filtered_q.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: filtered %0d arrived with nothing expected", $time, filtered_o);
      end else begin
        want = filtered_q.pop_front();
        if (filtered_o !== want) begin
          errors++;
          if (errors <= 100)
            $display("%0t: filtered expected %0d actual %0d", $time, want, filtered_o);
        end
      end
    end
  end

  // receiving side: random stalls, plus a long hold-off on request
  initial begin : sink
    int          hold_left;
    int unsigned served;
    hold_left = 0;
    served    = 0;
    forever begin
      @(posedge clk_i);
      if (served != hold_reqs) begin
        served    = hold_reqs;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (sink_gaps) begin
        out_ready_i <= ($urandom_range(99) >= 8);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // offer one word and return at the edge that takes it
  task automatic push_sample(input logic signed [SampleW-1:0] s);
    if (src_gaps && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // sender pauses until every owed word is back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? SampleMax : SampleMin;
      1:       begin v = $urandom_range(1023); return SampleW'(v - 512); end
      2:       begin v = $urandom_range(15); return SampleW'(v - 8); end
      3:       begin
                 v = $urandom_range(255);
                 return $urandom_range(1) ? SampleMax - SampleW'(v) : SampleMin + SampleW'(v);
               end
      default: return SampleW'($urandom);
    endcase
  endfunction

  // one negative full-scale word walks through every tap, the last one too;
  // a lone 1 shows truncation toward zero on negative products
  task automatic test_impulse();
    push_sample(SampleMin);
    for (int i = 1; i < TapsDef - 1; i++) begin
      push_sample((i == 12) ? SampleW'(1) : SampleW'(0));
    end
    push_sample(SampleMax);
    push_sample(-SampleW'(1));
    settle();
  endtask

  // long hold-off at the output while words keep coming, so the input stalls
  task automatic test_output_backpressure();
    src_gaps  = 1'b0;
    sink_gaps = 1'b1;
    hold_reqs++;
    for (int i = 0; i < 48; i++) push_sample(pick_sample());
    settle();
  endtask

  task automatic test_random_stream();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    for (int i = 0; i < 1000; i++) begin
      if (i == 250) begin
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
      end
      push_sample(pick_sample());
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_impulse();
    test_output_backpressure();
    test_random_stream();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
